// ----- design/dvrt_pkg.sv -----
`timescale 1ns / 1ps
package dvrt_pkg;

    localparam int NODE_COUNT = 16;
    localparam logic [7:0] UNREACHABLE = 8'd255;

    typedef enum logic [1:0] {
        OP_INSTALL = 2'd0,
        OP_ADVERT  = 2'd1,
        OP_TICK    = 2'd2,
        OP_LOOKUP  = 2'd3
    } t_op;

    localparam logic CFG_SELF_NODE = 1'b0;
    localparam logic CFG_DEAD_TIME = 1'b1;

    typedef struct packed {
        logic [1:0] operation;
        logic [3:0] neighbor_id;
        logic [3:0] destination;
        logic [3:0] learned_from;
        logic [7:0] hop_count;
    } t_in_item;

    typedef struct packed {
        logic       found;
        logic [3:0] via_node;
        logic [7:0] hops;
        logic       changed;
    } t_out_item;

    typedef struct packed {
        logic [1:0] operation;
        logic [3:0] neighbor_id;
        logic [3:0] destination;
        logic [7:0] cost;
        logic       skip;
        logic [NODE_COUNT-1:0] dead_mask;
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_TICK,
        ST_WRITE,
        ST_DONE
    } t_state;

endpackage

// ----- design/dvrt_front.sv -----
`timescale 1ns / 1ps
module dvrt_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  dvrt_pkg::t_in_item i_data,
    input  logic [3:0]         i_self_node,
    input  logic [7:0]         i_dead_time,
    output logic               o_cmd_valid,
    input  logic               i_cmd_take,
    output dvrt_pkg::t_cmd     o_cmd
);
    import dvrt_pkg::*;

    logic                  r_heard [NODE_COUNT];
    logic [7:0]            r_age   [NODE_COUNT];
    logic                  r_q_valid;
    t_cmd                  r_q;
    logic                  accept;
    t_cmd                  n_q;
    logic [NODE_COUNT-1:0] dead;
    logic [8:0]            age_inc [NODE_COUNT];

    assign o_stall     = r_q_valid;
    assign accept      = i_valid && !r_q_valid;
    assign o_cmd_valid = r_q_valid;
    assign o_cmd       = r_q;

    always_comb begin
        for (int k = 0; k < NODE_COUNT; k++) begin
            age_inc[k] = {1'b0, r_age[k]} + 9'd1;
            dead[k]    = r_heard[k] && (age_inc[k] > {1'b0, i_dead_time});
        end
        n_q.operation   = i_data.operation;
        n_q.neighbor_id = i_data.neighbor_id;
        n_q.destination = i_data.destination;
        n_q.cost        = (i_data.hop_count >= UNREACHABLE - 8'd1) ? UNREACHABLE
                        : i_data.hop_count + 8'd1;
        n_q.dead_mask   = dead;
        unique case (t_op'(i_data.operation))
            OP_INSTALL: n_q.skip = (i_data.destination == i_self_node);
            OP_ADVERT:  n_q.skip = (i_data.neighbor_id == i_self_node)
                                || (i_data.destination == i_self_node)
                                || (i_data.learned_from == i_self_node);
            OP_TICK:    n_q.skip = (dead == '0);
            OP_LOOKUP:  n_q.skip = 1'b0;
            default:    n_q.skip = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_valid <= 1'b0;
            for (int k = 0; k < NODE_COUNT; k++) begin
                r_heard[k] <= 1'b0;
                r_age[k]   <= '0;
            end
        end else begin
            if (accept) begin
                r_q_valid <= 1'b1;
                r_q       <= n_q;
                if (t_op'(i_data.operation) == OP_ADVERT
                        && i_data.neighbor_id != i_self_node) begin
                    r_heard[i_data.neighbor_id] <= 1'b1;
                    r_age[i_data.neighbor_id]   <= '0;
                end
                if (t_op'(i_data.operation) == OP_TICK) begin
                    for (int k = 0; k < NODE_COUNT; k++) begin
                        if (r_heard[k]) begin
                            r_age[k] <= dead[k] ? 8'd0 : age_inc[k][7:0];
                        end
                    end
                end
            end else if (i_cmd_take) begin
                r_q_valid <= 1'b0;
            end
        end
    end
endmodule

// ----- design/dvrt_back.sv -----
`timescale 1ns / 1ps
module dvrt_back #(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cmd_valid,
    output logic                o_cmd_take,
    input  dvrt_pkg::t_cmd      i_cmd,
    input  logic [3:0]          i_self_node,
    output logic                o_valid,
    input  logic                i_stall,
    output dvrt_pkg::t_out_item o_data
);
    import dvrt_pkg::*;

    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = $clog2(TABLE_ENTRIES + 1);

    t_state          r_state, n_state;
    logic [TABLE_ENTRIES-1:0] r_valid;
    logic [3:0]      r_dest [TABLE_ENTRIES];
    logic [3:0]      r_next [TABLE_ENTRIES];
    logic [3:0]      r_src  [TABLE_ENTRIES];
    logic [7:0]      r_cost [TABLE_ENTRIES];
    logic [CW-1:0]   r_idx;
    t_cmd            r_cmd;
    logic            r_hit, r_free_ok;
    logic [IW-1:0]   r_hit_idx, r_free_idx;
    logic            r_changed;
    logic            r_out_valid;
    t_out_item       r_out;

    logic [IW-1:0]   idx;
    logic            scan_last;
    logic            touch;
    logic            do_write;
    logic [IW-1:0]   w_idx;
    logic [3:0]      w_next, w_src;
    logic [7:0]      w_cost;
    logic            w_diff;
    t_out_item       result;

    assign idx        = r_idx[IW-1:0];
    assign scan_last  = (r_idx == CW'(TABLE_ENTRIES - 1));
    assign o_cmd_take = (r_state == ST_IDLE) && i_cmd_valid && !r_out_valid;
    assign o_valid    = r_out_valid;
    assign o_data     = r_out;
    assign touch = r_valid[idx] && (r_cost[idx] != UNREACHABLE)
                && (r_cmd.dead_mask[r_dest[idx]] || r_cmd.dead_mask[r_next[idx]]
                    || r_cmd.dead_mask[r_src[idx]]);

    always_comb begin
        do_write = 1'b0;
        w_idx    = r_hit ? r_hit_idx : r_free_idx;
        w_next   = r_cmd.neighbor_id;
        w_src    = r_cmd.neighbor_id;
        w_cost   = r_cmd.cost;
        if (t_op'(r_cmd.operation) == OP_INSTALL) begin
            w_next   = r_cmd.destination;
            w_src    = i_self_node;
            w_cost   = 8'd1;
            do_write = r_hit || r_free_ok;
        end else if (r_hit) begin
            do_write = (r_next[r_hit_idx] == r_cmd.neighbor_id
                        && r_src[r_hit_idx] == r_cmd.neighbor_id)
                    || (r_cmd.cost < r_cost[r_hit_idx]);
        end else begin
            do_write = r_free_ok && (r_cmd.cost != UNREACHABLE);
        end
        w_diff = !r_hit || r_next[w_idx] != w_next || r_src[w_idx] != w_src
              || r_cost[w_idx] != w_cost;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (o_cmd_take) begin
                n_state = i_cmd.skip ? ST_DONE
                        : (t_op'(i_cmd.operation) == OP_TICK) ? ST_TICK : ST_SCAN;
            end
            ST_SCAN:  if (scan_last) begin
                n_state = (t_op'(r_cmd.operation) == OP_LOOKUP) ? ST_DONE : ST_WRITE;
            end
            ST_TICK:  if (scan_last) n_state = ST_DONE;
            ST_WRITE: n_state = ST_DONE;
            ST_DONE:  n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        result = '0;
        if (t_op'(r_cmd.operation) == OP_LOOKUP) begin
            result.found    = r_hit;
            result.via_node = r_hit ? r_next[r_hit_idx] : 4'd0;
            result.hops     = r_hit ? r_cost[r_hit_idx] : UNREACHABLE;
        end else begin
            result.changed  = r_changed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_out_valid && !i_stall) r_out_valid <= 1'b0;
            unique case (r_state)
                ST_IDLE: if (o_cmd_take) begin
                    r_cmd     <= i_cmd;
                    r_idx     <= '0;
                    r_hit     <= 1'b0;
                    r_free_ok <= 1'b0;
                    r_changed <= 1'b0;
                end
                ST_SCAN: begin
                    r_idx <= r_idx + CW'(1);
                    if (r_valid[idx] && r_dest[idx] == r_cmd.destination && !r_hit) begin
                        r_hit     <= 1'b1;
                        r_hit_idx <= idx;
                    end
                    if (!r_valid[idx] && !r_free_ok) begin
                        r_free_ok  <= 1'b1;
                        r_free_idx <= idx;
                    end
                end
                ST_TICK: begin
                    r_idx <= r_idx + CW'(1);
                    if (touch) begin
                        r_cost[idx] <= UNREACHABLE;
                        r_changed   <= 1'b1;
                    end
                end
                ST_WRITE: if (do_write) begin
                    r_valid[w_idx] <= 1'b1;
                    r_dest[w_idx]  <= r_cmd.destination;
                    r_next[w_idx]  <= w_next;
                    r_src[w_idx]   <= w_src;
                    r_cost[w_idx]  <= w_cost;
                    r_changed      <= w_diff;
                end
                ST_DONE: begin
                    r_out_valid <= 1'b1;
                    r_out       <= result;
                end
                default: ;
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE) |=> r_out_valid)
        else $error("result not posted");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_take |-> !r_out_valid)
        else $error("took command with result pending");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WRITE) |=> $stable(r_cmd))
        else $error("command changed during write");
endmodule

// ----- design/distance_vector_route_table.sv -----
`timescale 1ns / 1ps
// channel  direction  payload     handshake
// in       input      t_in_item   i_valid / o_stall
// out      output     t_out_item  o_valid / i_stall
// cfg      input      index,data  i_cfg_we
// an update scans the table one entry per cycle, then writes its entry and posts the result;
// a lookup or a tick with a dead neighbor scans and then posts, and a skipped item only posts
// reset is synchronous and active low and clears route valid bits and neighbor ages
// one item waits in the front queue while the back works; a stalled result holds the back
module distance_vector_route_table #(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  dvrt_pkg::t_in_item  i_data,
    output logic                o_valid,
    input  logic                i_stall,
    output dvrt_pkg::t_out_item o_data,
    input  logic                i_cfg_we,
    input  logic                i_cfg_index,
    input  logic [7:0]          i_cfg_data
);
    import dvrt_pkg::*;

    logic [3:0] r_self_node;
    logic [7:0] r_dead_time;
    logic       cmd_valid, cmd_take;
    t_cmd       cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_self_node <= 4'd0;
            r_dead_time <= 8'd3;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SELF_NODE: r_self_node <= i_cfg_data[3:0];
                CFG_DEAD_TIME: r_dead_time <= i_cfg_data;
                default: ;
            endcase
        end
    end

    dvrt_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_data,
        .i_self_node(r_self_node), .i_dead_time(r_dead_time),
        .o_cmd_valid(cmd_valid), .i_cmd_take(cmd_take), .o_cmd(cmd)
    );

    dvrt_back #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_back (
        .i_clk, .i_rst_n, .i_cmd_valid(cmd_valid), .o_cmd_take(cmd_take), .i_cmd(cmd),
        .i_self_node(r_self_node), .o_valid, .i_stall, .o_data
    );
endmodule
